// File: hw/rtl/strided_dma_load_sequencer_assert.svh
// assertion macros used by the checker of the strided load sequencer
`ifndef STRIDED_DMA_LOAD_SEQUENCER_ASSERT_SVH
`define STRIDED_DMA_LOAD_SEQUENCER_ASSERT_SVH

// expression must never be true outside reset
`define SDLS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SDLS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SDLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sdls_pkg.sv
// types and constants of the strided load sequencer
package sdls_pkg;

  // command codes carried in tuser
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_CONFIG = 3'd1;
  localparam logic [2:0] CMD_MOVE_0 = 3'd2;
  localparam logic [2:0] CMD_MOVE_1 = 3'd3;
  localparam logic [2:0] CMD_MOVE_2 = 3'd4;

  // packed beat widths and bus widths (whole bytes)
  localparam int SDLS_IN_BITS  = 157;
  localparam int SDLS_IN_W     = 160;
  localparam int SDLS_OUT_BITS = 147;
  localparam int SDLS_OUT_W    = 152;

  // input beat, last member in the lowest bits
  typedef struct packed {
    logic        request_space;
    logic        completion_ready;
    logic [15:0] response_bytes;
    logic        response_valid;
    logic [15:0] col_count;
    logic [7:0]  row_count;
    logic [15:0] local_row;
    logic [15:0] block_stride_in;
    logic [1:0]  config_slot;
    logic [63:0] address_or_stride;
    logic [15:0] command_tag;
  } sdls_in_t;

  // result beat, last member in the lowest bits
  typedef struct packed {
    logic [15:0] done_tag;
    logic        done_valid;
    logic [15:0] request_tag;
    logic [15:0] request_block_stride;
    logic [15:0] request_cols;
    logic [15:0] request_local;
    logic [63:0] request_address;
    logic        request_valid;
    logic        command_taken;
  } sdls_out_t;

endpackage

// File: hw/rtl/strided_dma_load_sequencer.sv
// strided load sequencer: one tick per beat, row reads one at a time
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser command, s_tdata other tick inputs
//  m_*       out  m_tvalid/m_tready  m_tdata tick results
//
// each accepted beat is one tick; its registered result shows on m_* the next
// cycle if m_* is free; a beat can be taken every cycle that s_tready is high
// the path per beat is one 9x32 multiply and a 64-bit add for the row address
// an output register plus a one-beat skid register part the two sides;
// s_tready drops only while the skid register holds a beat
// rst is synchronous; slot strides reset to DIM, state and valid flags to zero
module strided_dma_load_sequencer
  import sdls_pkg::*;
#(
  parameter int DIM   = 16,
  parameter int SLOTS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // command_tag, address_or_stride, config_slot, block_stride_in, local_row,
  // row_count, col_count, response_valid, response_bytes, completion_ready,
  // request_space, zero fill
  input  logic [SDLS_IN_W-1:0]  s_tdata,
  // command
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // command_taken, request_valid, request_address, request_local, request_cols,
  // request_block_stride, request_tag, done_valid, done_tag, zero fill
  output logic [SDLS_OUT_W-1:0] m_tdata
);

  sdls_in_t    in_d;
  logic [2:0]  cmd;
  logic        accept;

  // slot tables
  logic [31:0] slot_row_stride   [SLOTS];
  logic [15:0] slot_block_stride [SLOTS];

  // sequencer state
  logic        busy, busy_next;
  logic        finished, finished_next;
  logic [15:0] active_tag, active_tag_next;
  logic [63:0] base_address, base_address_next;
  logic [15:0] base_local, base_local_next;
  logic [7:0]  rows_total, rows_total_next;
  logic [15:0] cols_total, cols_total_next;
  logic [8:0]  row_index, row_index_next;
  logic        in_flight, in_flight_next;
  logic [31:0] active_row_stride, active_row_stride_next;
  logic [15:0] active_block_stride, active_block_stride_next;
  logic [23:0] expected_total, expected_total_next;
  logic [31:0] returned_total, returned_total_next;

  logic        done;
  logic        cmd_known;
  logic        cfg_wr;
  logic        issue;
  logic [2:0]  move_slot;
  logic [31:0] sel_row_stride;
  logic [15:0] sel_block_stride;
  logic [40:0] row_offset;
  logic [31:0] returned_sum;
  sdls_out_t   result;

  // output and skid registers
  logic        out_valid;
  sdls_out_t   out_data;
  logic        skid_valid;
  sdls_out_t   skid_data;

  assign in_d   = s_tdata[SDLS_IN_BITS-1:0];
  assign cmd    = s_tuser;
  assign accept = s_tvalid && s_tready;

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(SDLS_OUT_W-SDLS_OUT_BITS){1'b0}}, out_data};

  // decode
  assign done      = busy && finished;
  assign cmd_known = (cmd == CMD_CONFIG) || (cmd == CMD_MOVE_0) ||
                     (cmd == CMD_MOVE_1) || (cmd == CMD_MOVE_2);
  assign cfg_wr    = accept && !busy && (cmd == CMD_CONFIG);
  assign move_slot = cmd - CMD_MOVE_0;
  assign issue     = busy && !finished && !in_flight &&
                     (row_index < {1'b0, rows_total}) && in_d.request_space;
  assign row_offset   = {32'b0, row_index} * {9'b0, active_row_stride};
  assign returned_sum = returned_total + {16'b0, in_d.response_bytes};

  // slot lookup for a move-in, out-of-range slots fall back to slot 0
  always_comb begin
    sel_row_stride   = slot_row_stride[0];
    sel_block_stride = slot_block_stride[0];
    for (int i = 0; i < SLOTS; i++) begin
      if (32'(move_slot) == i) begin
        sel_row_stride   = slot_row_stride[i];
        sel_block_stride = slot_block_stride[i];
      end
    end
  end

  // next state and result of one tick
  always_comb begin
    busy_next                = busy;
    finished_next            = finished;
    active_tag_next          = active_tag;
    base_address_next        = base_address;
    base_local_next          = base_local;
    rows_total_next          = rows_total;
    cols_total_next          = cols_total;
    row_index_next           = row_index;
    in_flight_next           = in_flight;
    active_row_stride_next   = active_row_stride;
    active_block_stride_next = active_block_stride;
    expected_total_next      = expected_total;
    returned_total_next      = returned_total;
    result                   = '0;

    result.done_valid = done;
    result.done_tag   = done ? active_tag : 16'b0;

    // completion handshake, else command acceptance
    if (done && in_d.completion_ready) begin
      busy_next     = 1'b0;
      finished_next = 1'b0;
    end else if (!busy && cmd_known) begin
      result.command_taken = 1'b1;
      busy_next            = 1'b1;
      finished_next        = 1'b0;
      active_tag_next      = in_d.command_tag;
      if (cmd == CMD_CONFIG) begin
        finished_next = 1'b1;
      end else begin
        base_address_next        = in_d.address_or_stride;
        base_local_next          = in_d.local_row;
        rows_total_next          = in_d.row_count;
        cols_total_next          = in_d.col_count;
        row_index_next           = 9'b0;
        in_flight_next           = 1'b0;
        active_row_stride_next   = sel_row_stride;
        active_block_stride_next = sel_block_stride;
        expected_total_next      = {16'b0, in_d.row_count} * {8'b0, in_d.col_count};
        returned_total_next      = 32'b0;
      end
    end

    // row read issue from the state at tick start
    if (issue) begin
      result.request_valid        = 1'b1;
      result.request_address      = base_address + {23'b0, row_offset};
      result.request_local        = base_local + {7'b0, row_index};
      result.request_cols         = cols_total;
      result.request_block_stride = active_block_stride;
      result.request_tag          = active_tag;
      in_flight_next              = 1'b1;
      row_index_next              = row_index + 9'd1;
    end

    // dma response, always taken
    if (in_d.response_valid) begin
      returned_total_next = returned_sum;
      in_flight_next      = 1'b0;
      finished_next       = returned_sum >= {8'b0, expected_total};
    end
  end

  // slot tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_row_stride[i]   <= 32'(DIM);
        slot_block_stride[i] <= 16'(DIM);
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (32'(in_d.config_slot) == i) begin
          slot_row_stride[i]   <= in_d.address_or_stride[31:0];
          slot_block_stride[i] <= in_d.block_stride_in;
        end
      end
    end
  end

  // sequencer state, advances once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy                <= 1'b0;
      finished            <= 1'b0;
      active_tag          <= '0;
      base_address        <= '0;
      base_local          <= '0;
      rows_total          <= '0;
      cols_total          <= '0;
      row_index           <= '0;
      in_flight           <= 1'b0;
      active_row_stride   <= '0;
      active_block_stride <= '0;
      expected_total      <= '0;
      returned_total      <= '0;
    end else if (accept) begin
      busy                <= busy_next;
      finished            <= finished_next;
      active_tag          <= active_tag_next;
      base_address        <= base_address_next;
      base_local          <= base_local_next;
      rows_total          <= rows_total_next;
      cols_total          <= cols_total_next;
      row_index           <= row_index_next;
      in_flight           <= in_flight_next;
      active_row_stride   <= active_row_stride_next;
      active_block_stride <= active_block_stride_next;
      expected_total      <= expected_total_next;
      returned_total      <= returned_total_next;
    end
  end

  // output and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

// File: hw/rtl/sdls_checker.sv
// port-level checker of the strided load sequencer and its bind
`include "strided_dma_load_sequencer_assert.svh"

module sdls_checker
  import sdls_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [SDLS_OUT_W-1:0] m_tdata
);

  sdls_out_t o;
  logic      beat_in_empty;

  assign o             = m_tdata[SDLS_OUT_BITS-1:0];
  assign beat_in_empty = s_tvalid && s_tready && !m_tvalid;

  // a stalled result stays offered
  `SDLS_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // a beat taken with the output empty shows its result next cycle
  `SDLS_ASSERT_NEXT(a_latency, clk, rst, beat_in_empty, m_tvalid, "result of beat not delivered")

  // a row read never goes out while a completion is offered
  `SDLS_ASSERT_NEVER(a_req_done, clk, rst, m_tvalid && o.request_valid && o.done_valid, "read issued while done")

  // a command is never taken while a completion is offered
  `SDLS_ASSERT_NEVER(a_take_done, clk, rst, m_tvalid && o.command_taken && o.done_valid, "command taken while done")

  // completion tag reads zero when no completion is offered
  `SDLS_ASSERT_IMPL(a_tag_zero, clk, rst, m_tvalid && !o.done_valid, o.done_tag == 16'b0, "stray done tag")

endmodule

bind strided_dma_load_sequencer sdls_checker u_sdls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
